@@ src/gbp_pkg.sv @@
`timescale 1ns / 1ps

package gbp_pkg;

    localparam int BTB_INDEX_BITS = 10;
    localparam int HISTORY_BITS   = 8;
    localparam int PC_W           = 64;
    localparam int CTR_W          = 2;

    // sweep covers the deeper of the two tables
    localparam int CLR_BITS = (BTB_INDEX_BITS > HISTORY_BITS) ? BTB_INDEX_BITS : HISTORY_BITS;

    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_UPDATE  = 1'b1;

    localparam logic [CTR_W-1:0] CTR_MAX = '1;
    localparam logic [CTR_W-1:0] CTR_MIN = '0;

    typedef struct packed {
        logic            valid;
        logic            cond;
        logic [PC_W-1:0] tag;
        logic [PC_W-1:0] target;
    } btb_entry_t;

    localparam int BTB_ENTRY_W = $bits(btb_entry_t);

    typedef struct packed {
        logic                active;
        logic [CLR_BITS-1:0] addr;
    } clr_t;

    // 2-bit saturating counter step towards the outcome
    function automatic logic [CTR_W-1:0] ctr_step(input logic [CTR_W-1:0] c,
                                                  input logic taken);
        logic [CTR_W-1:0] r;
        r = c;
        if (taken)
        begin
            if (c != CTR_MAX)
                r = c + CTR_W'(1);
        end
        else
        begin
            if (c != CTR_MIN)
                r = c - CTR_W'(1);
        end
        return r;
    endfunction

endpackage

@@ src/gbp_ram.sv @@
`timescale 1ns / 1ps

// simple dual-port RAM, one write and one registered read port
module gbp_ram #(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [(1 << ADDR_BITS)];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

@@ src/gbp_clear.sv @@
`timescale 1ns / 1ps

// post-reset sweep: one address per cycle over both tables
module gbp_clear
    import gbp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    output clr_t clr
);

    logic                active_reg, active_next;
    logic [CLR_BITS-1:0] addr_reg, addr_next;

    always_comb
    begin
        active_next = active_reg;
        addr_next   = addr_reg;
        if (active_reg)
        begin
            addr_next = addr_reg + CLR_BITS'(1);
            if (addr_reg == '1)
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            addr_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            addr_reg   <= addr_next;
        end
    end

    assign clr.active = active_reg;
    assign clr.addr   = addr_reg;

endmodule

@@ src/gshare_btb_branch_predictor.sv @@
`timescale 1ns / 1ps

// gshare branch predictor with a direct-mapped branch target buffer.
// A beat with tuser = 0 is a predict: it returns one output beat with the next
// fetch PC (stored target on a hit to an unconditional entry, or to a
// conditional entry whose 2-bit counter is 2 or 3; otherwise PC+4) and a miss
// flag. A beat with tuser = 1 is an update: it gives no output beat, trains
// the counter (conditional branches only, indexed with the history before the
// update), shifts the outcome of a conditional branch into the 8-bit global
// history and overwrites the target buffer entry. The buffer is indexed by PC
// bits 11:2 and tagged with the full PC; the counter table by PC bits 9:2 XOR the history.
// Flow: a beat is accepted, then the target buffer and counter RAMs are read
// through their registered read ports, followed by the output load or
// write-back; no new beat is accepted until the last one is through. After
// reset a clearing pass sweeps both RAMs; s_tready stays low until it ends.
// An output beat left waiting holds off the next predict's result and, with
// it, the next input acceptance.
module gshare_btb_branch_predictor
    import gbp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // pc[63:0], taken[64], conditional[65], target[129:66]
    input  logic         s_tuser,   // kind: 0 predict, 1 update
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata    // next_pc[63:0], btb_miss[64]
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    clr_t clr;

    logic state_reg, state_next;

    // item held for the lookup cycle
    logic                    kind_reg;
    logic [PC_W-1:0]         pc_reg;
    logic                    taken_reg;
    logic                    cond_reg;
    logic [PC_W-1:0]         target_reg;
    logic [HISTORY_BITS-1:0] pht_idx_reg;

    logic [HISTORY_BITS-1:0] history_reg, history_next;

    logic            out_valid_reg, out_valid_next;
    logic [PC_W-1:0] out_pc_reg;
    logic            out_miss_reg;

    // unpacked input beat
    logic [PC_W-1:0] in_pc;
    logic            in_taken;
    logic            in_cond;
    logic [PC_W-1:0] in_target;
    logic            accept;

    // RAM ports
    logic                      btb_we;
    logic [BTB_INDEX_BITS-1:0] btb_waddr;
    btb_entry_t                btb_wdata;
    btb_entry_t                btb_rdata;
    logic [BTB_INDEX_BITS-1:0] btb_raddr;
    logic                      pht_we;
    logic [HISTORY_BITS-1:0]   pht_waddr;
    logic [CTR_W-1:0]          pht_wdata;
    logic [CTR_W-1:0]          pht_rdata;
    logic [HISTORY_BITS-1:0]   pht_raddr;

    // lookup results
    logic            hit;
    logic            use_target;
    logic            load_out;
    logic            do_update;

    assign in_pc     = s_tdata[63:0];
    assign in_taken  = s_tdata[64];
    assign in_cond   = s_tdata[65];
    assign in_target = s_tdata[129:66];

    assign s_tready = !clr.active && (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign btb_raddr = in_pc[2 +: BTB_INDEX_BITS];
    assign pht_raddr = in_pc[2 +: HISTORY_BITS] ^ history_reg;

    gbp_clear u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (clr)
    );

    gbp_ram #(
        .WIDTH     (BTB_ENTRY_W),
        .ADDR_BITS (BTB_INDEX_BITS)
    ) u_btb_ram (
        .clk   (clk),
        .we    (btb_we),
        .waddr (btb_waddr),
        .wdata (btb_wdata),
        .re    (accept),
        .raddr (btb_raddr),
        .rdata (btb_rdata)
    );

    gbp_ram #(
        .WIDTH     (CTR_W),
        .ADDR_BITS (HISTORY_BITS)
    ) u_pht_ram (
        .clk   (clk),
        .we    (pht_we),
        .waddr (pht_waddr),
        .wdata (pht_wdata),
        .re    (accept),
        .raddr (pht_raddr),
        .rdata (pht_rdata)
    );

    // prediction from the read data
    assign hit        = btb_rdata.valid && (btb_rdata.tag == pc_reg);
    assign use_target = hit && (!btb_rdata.cond || pht_rdata[CTR_W-1]);

    assign do_update = (state_reg == ST_LOOKUP) && (kind_reg == KIND_UPDATE);
    assign load_out  = (state_reg == ST_LOOKUP) && (kind_reg == KIND_PREDICT)
                       && (!out_valid_reg || m_tready);

    // write-back; the sweep never overlaps an item
    always_comb
    begin
        btb_we           = 1'b0;
        btb_waddr        = pc_reg[2 +: BTB_INDEX_BITS];
        btb_wdata.valid  = 1'b1;
        btb_wdata.cond   = cond_reg;
        btb_wdata.tag    = pc_reg;
        btb_wdata.target = target_reg;
        pht_we           = 1'b0;
        pht_waddr        = pht_idx_reg;
        pht_wdata        = ctr_step(pht_rdata, taken_reg);
        if (clr.active)
        begin
            btb_we          = 1'b1;
            btb_waddr       = clr.addr[BTB_INDEX_BITS-1:0];
            btb_wdata.valid = 1'b0;
            btb_wdata.cond  = 1'b0;
            btb_wdata.tag   = '0;
            pht_we          = 1'b1;
            pht_waddr       = clr.addr[HISTORY_BITS-1:0];
            pht_wdata       = CTR_MIN;
        end
        else if (do_update)
        begin
            btb_we = 1'b1;
            pht_we = cond_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        history_next   = history_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                if (do_update)
                begin
                    state_next = ST_IDLE;
                    if (cond_reg)
                        history_next = {history_reg[HISTORY_BITS-2:0], taken_reg};
                end
                else if (load_out)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            history_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            history_reg   <= history_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= s_tuser;
            pc_reg      <= in_pc;
            taken_reg   <= in_taken;
            cond_reg    <= in_cond;
            target_reg  <= in_target;
            pht_idx_reg <= pht_raddr;
        end
        if (load_out)
        begin
            out_pc_reg   <= use_target ? btb_rdata.target : (pc_reg + PC_W'(4));
            out_miss_reg <= !hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_miss_reg, out_pc_reg};

    // no beat is taken while the tables are being swept
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !clr.active)
    else $error("input beat accepted during clearing pass");

    // a new output beat only ever follows a predict lookup
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_LOOKUP && kind_reg == KIND_PREDICT))
    else $error("output beat not caused by a predict");

    // history moves only on a conditional update
    assert property (@(posedge clk) disable iff (!rst_n)
        (history_reg != $past(history_reg))
            |-> $past(state_reg == ST_LOOKUP && kind_reg == KIND_UPDATE && cond_reg))
    else $error("history changed outside a conditional update");

endmodule
